// ===== sv/kpd_pkg.sv =====
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types and constants for the keypad debounce and hold block.
// ----------------------------------------------------------------------------
package kpd_pkg;

    localparam int ROWS = 4;
    localparam int COLS = 4;
    localparam int KEY_CNT = ROWS * COLS;

    localparam int KEY_IDX_W = 4;
    localparam int KEY_SLOTS = 2 ** KEY_IDX_W;
    localparam int CNT_CMP_W = 8;

    localparam int TIME_W = 32;
    localparam int TALLY_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [TIME_W-1:0]  HOLD_TIME_RST = 32'd500;
    localparam logic [TALLY_W-1:0] DEBOUNCE_RST  = 8'd3;
    localparam logic [TALLY_W-1:0] TALLY_MAX     = 8'hFF;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_HOLD     = 2'd2,
        PH_RELEASED = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PRESSED  = 3'd1,
        EV_HOLD     = 3'd2,
        EV_REPEAT   = 3'd3,
        EV_RELEASED = 3'd4,
        EV_IDLE     = 3'd5
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_TIME = 1'd0,
        REG_DEBOUNCE  = 1'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_UPDATE = 2'd1,
        ST_RESULT = 2'd2
    } t_state;

    typedef struct packed {
        logic capture;
        logic update;
    } t_cmd;

endpackage

// ===== sv/kpd_if.sv =====
// ----------------------------------------------------------------------------
// kpd_if
// Channel interfaces: key sample in, key event out, register writes in.
// ----------------------------------------------------------------------------
interface kpd_key_if
    import kpd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [KEY_IDX_W-1:0] key_index;
    logic                 key_down;
    logic [TIME_W-1:0]    now_ms;

    modport source (output valid, key_index, key_down, now_ms, input ready);
    modport sink   (input valid, key_index, key_down, now_ms, output ready);
endinterface

interface kpd_evt_if
    import kpd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [2:0]           key_event;
    logic [KEY_IDX_W-1:0] event_key;
    logic                 any_down;

    modport source (output valid, key_event, event_key, any_down, input ready);
    modport sink   (input valid, key_event, event_key, any_down, output ready);
endinterface

interface kpd_cfg_if
    import kpd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== sv/kpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// kpd_ctrl
// Sequencer: take a sample word, run one entry update, hold the event word.
// ----------------------------------------------------------------------------
module kpd_ctrl
    import kpd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.update   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            ST_RESULT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    a_capture_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.update)
        else $error("capture not followed by update");

    a_update_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |=> (o_out_valid && !o_in_ready))
        else $error("update not followed by event word");

    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> (o_in_ready && !o_out_valid))
        else $error("input not freed after event word taken");

endmodule

// ===== sv/kpd_dp.sv =====
// ----------------------------------------------------------------------------
// kpd_dp
// Per-key phase, debounce tally and time stamp, with the register file.
// ----------------------------------------------------------------------------
module kpd_dp
    import kpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [KEY_IDX_W-1:0] i_key_index,
    input  logic                 i_key_down,
    input  logic [TIME_W-1:0]    i_now_ms,
    kpd_cfg_if.sink              cfg,
    output logic [2:0]           o_key_event,
    output logic [KEY_IDX_W-1:0] o_event_key,
    output logic                 o_any_down
);

    logic [TIME_W-1:0]    r_hold_time;
    logic [TALLY_W-1:0]   r_debounce;

    logic [KEY_IDX_W-1:0] r_key_index;
    logic                 r_key_down;
    logic [TIME_W-1:0]    r_now;
    t_event               r_event;

    t_phase               r_phase [KEY_SLOTS];
    logic [TALLY_W-1:0]   r_tally [KEY_SLOTS];
    logic [TIME_W-1:0]    r_stamp [KEY_SLOTS];

    t_phase               cur_phase;
    logic [TALLY_W-1:0]   cur_tally;
    logic [TIME_W-1:0]    cur_stamp;
    logic                 in_range;
    logic                 elapsed;
    logic [TALLY_W-1:0]   tally_inc;
    logic                 hit;

    t_phase               n_phase;
    logic [TALLY_W-1:0]   n_tally;
    logic [TIME_W-1:0]    n_stamp;
    t_event               n_event;

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_time <= HOLD_TIME_RST;
            r_debounce  <= DEBOUNCE_RST;
        end else if (cfg.valid) begin
            case (t_cfg_reg'(cfg.reg_index))
                REG_HOLD_TIME: r_hold_time <= cfg.wr_data;
                REG_DEBOUNCE:  r_debounce  <= cfg.wr_data[TALLY_W-1:0];
                default:       r_debounce  <= r_debounce;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key_index <= i_key_index;
            r_key_down  <= i_key_down;
            r_now       <= i_now_ms;
        end
    end

    assign cur_phase = r_phase[r_key_index];
    assign cur_tally = r_tally[r_key_index];
    assign cur_stamp = r_stamp[r_key_index];
    assign in_range  = CNT_CMP_W'(r_key_index) < CNT_CMP_W'(KEY_CNT);
    assign elapsed   = (r_now - cur_stamp) >= r_hold_time;
    assign tally_inc = (cur_tally != TALLY_MAX) ? cur_tally + 1'b1 : cur_tally;
    assign hit       = tally_inc >= r_debounce;

    always_comb begin
        n_phase = cur_phase;
        n_tally = cur_tally;
        n_stamp = cur_stamp;
        n_event = EV_NONE;
        if (r_key_down) begin
            case (cur_phase)
                PH_IDLE: begin
                    n_tally = hit ? '0 : tally_inc;
                    if (hit) begin
                        n_phase = PH_PRESSED;
                        n_stamp = r_now;
                        n_event = EV_PRESSED;
                    end
                end
                PH_PRESSED: begin
                    if (elapsed) begin
                        n_phase = PH_HOLD;
                        n_stamp = r_now;
                        n_event = EV_HOLD;
                    end
                end
                PH_HOLD: begin
                    if (elapsed) begin
                        n_stamp = r_now;
                        n_event = EV_REPEAT;
                    end
                end
                default: begin
                    n_event = EV_NONE;
                end
            endcase
        end else begin
            case (cur_phase)
                PH_PRESSED, PH_HOLD: begin
                    n_tally = hit ? '0 : tally_inc;
                    if (hit) begin
                        n_phase = PH_RELEASED;
                        n_event = EV_RELEASED;
                    end
                end
                PH_RELEASED: begin
                    n_phase = PH_IDLE;
                    n_event = EV_IDLE;
                end
                default: begin
                    n_event = EV_NONE;
                end
            endcase
        end
        if (!in_range) begin
            n_event = EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_SLOTS; k++) begin
                r_phase[k] <= PH_IDLE;
                r_tally[k] <= '0;
                r_stamp[k] <= '0;
            end
        end else if (i_cmd.update && in_range) begin
            r_phase[r_key_index] <= n_phase;
            r_tally[r_key_index] <= n_tally;
            r_stamp[r_key_index] <= n_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_event <= n_event;
        end
    end

    assign o_key_event = r_event;
    assign o_event_key = r_key_index;
    assign o_any_down  = r_key_down;

    a_press_stamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && in_range && n_event == EV_PRESSED)
        |=> (r_phase[r_key_index] == PH_PRESSED && r_stamp[r_key_index] == r_now))
        else $error("press not recorded in key entry");

    a_outside_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && !in_range) |=> (r_event == EV_NONE))
        else $error("event raised for key outside the keypad");

    a_up_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && !r_key_down)
        |=> (r_event != EV_HOLD && r_event != EV_REPEAT && r_event != EV_PRESSED))
        else $error("hold or press event on an open key");

endmodule

// ===== sv/keypad_key_debounce_hold_fsm.sv =====
// ----------------------------------------------------------------------------
// keypad_key_debounce_hold_fsm
// Debounce and hold/repeat tracking for the keys of a matrix keypad.
//
//   channel   dir  handshake            word
//   i_key     in   i_key.valid/ready    key_index, key_down, now_ms
//   o_evt     out  o_evt.valid/ready    key_event, event_key, any_down
//   i_cfg     in   i_cfg.valid/ready    reg_index, wr_data (always ready)
//
// A sample word goes through capture, one read-modify-write of the
// key entry in the per-key register file, then the event word is shown.
// The event word stays valid and the input stays not ready until it is taken.
// Reset sets every key idle with zero tally and stamp at once; no sweep.
// ----------------------------------------------------------------------------
module keypad_key_debounce_hold_fsm
    import kpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    kpd_key_if.sink  i_key,
    kpd_evt_if.source o_evt,
    kpd_cfg_if.sink  i_cfg
);

    t_cmd cmd;

    kpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_key.valid),
        .o_in_ready  (i_key.ready),
        .o_out_valid (o_evt.valid),
        .i_out_ready (o_evt.ready),
        .o_cmd       (cmd)
    );

    kpd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_key_index (i_key.key_index),
        .i_key_down  (i_key.key_down),
        .i_now_ms    (i_key.now_ms),
        .cfg         (i_cfg),
        .o_key_event (o_evt.key_event),
        .o_event_key (o_evt.event_key),
        .o_any_down  (o_evt.any_down)
    );

endmodule

// ===== tb/kpd_event_checker.sv =====
// ----------------------------------------------------------------------------
// kpd_event_checker
// Watches the sample, event and register channels of the keypad block. It
// keeps its own per-key phase, tally and stamp, predicts the event word of
// each accepted sample and compares every accepted event word with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module kpd_event_checker
    import kpd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    kpd_key_if   i_key,
    kpd_evt_if   i_evt,
    kpd_cfg_if   i_cfg,
    output int   o_pending,
    output int   o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]           key_event;
        logic [KEY_IDX_W-1:0] event_key;
        logic                 any_down;
    } t_evt_word;

    t_phase               phase_q [KEY_SLOTS];
    logic [TALLY_W-1:0]   tally_q [KEY_SLOTS];
    logic [TIME_W-1:0]    stamp_q [KEY_SLOTS];
    logic [TIME_W-1:0]    hold_ms_q;
    logic [TALLY_W-1:0]   debounce_lim_q;
    t_evt_word            expected_events [$];
    int                   fail_total;

    function automatic logic count_qualify(input logic [KEY_IDX_W-1:0] k);
        if (tally_q[k] != TALLY_MAX)
            tally_q[k] = tally_q[k] + 1'b1;
        if (tally_q[k] >= debounce_lim_q) begin
            tally_q[k] = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_evt_word next_event(input logic [KEY_IDX_W-1:0] k,
                                             input logic down,
                                             input logic [TIME_W-1:0] now);
        t_evt_word         w;
        logic [TIME_W-1:0] since;
        logic              elapsed;
        w.key_event = EV_NONE;
        w.event_key = k;
        w.any_down  = down;
        if (int'(k) < KEY_CNT) begin
            since   = now - stamp_q[k];
            elapsed = (since >= hold_ms_q);
            if (down) begin
                case (phase_q[k])
                    PH_IDLE: begin
                        if (count_qualify(k)) begin
                            phase_q[k]  = PH_PRESSED;
                            stamp_q[k]  = now;
                            w.key_event = EV_PRESSED;
                        end
                    end
                    PH_PRESSED: begin
                        if (elapsed) begin
                            phase_q[k]  = PH_HOLD;
                            stamp_q[k]  = now;
                            w.key_event = EV_HOLD;
                        end
                    end
                    PH_HOLD: begin
                        if (elapsed) begin
                            stamp_q[k]  = now;
                            w.key_event = EV_REPEAT;
                        end
                    end
                    default: ;
                endcase
            end else begin
                case (phase_q[k])
                    PH_PRESSED, PH_HOLD: begin
                        if (count_qualify(k)) begin
                            phase_q[k]  = PH_RELEASED;
                            w.key_event = EV_RELEASED;
                        end
                    end
                    PH_RELEASED: begin
                        phase_q[k]  = PH_IDLE;
                        w.key_event = EV_IDLE;
                    end
                    default: ;
                endcase
            end
        end
        return w;
    endfunction

    task automatic flag_field(input string name, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        t_evt_word want;
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_SLOTS; k++) begin
                phase_q[k] = PH_IDLE;
                tally_q[k] = '0;
                stamp_q[k] = '0;
            end
            hold_ms_q      = HOLD_TIME_RST;
            debounce_lim_q = DEBOUNCE_RST;
            expected_events.delete();
            fail_total     = 0;
            o_pending     <= 0;
            o_fail_count  <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.reg_index)
                    REG_HOLD_TIME: hold_ms_q      = i_cfg.wr_data;
                    REG_DEBOUNCE:  debounce_lim_q = i_cfg.wr_data[TALLY_W-1:0];
                    default: ;
                endcase
            end
            if (i_key.valid && i_key.ready)
                expected_events.push_back(next_event(i_key.key_index, i_key.key_down,
                                                     i_key.now_ms));
            if (i_evt.valid && i_evt.ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event word, expected none, actual %0d/%0d/%0d",
                             $time, i_evt.key_event, i_evt.event_key, i_evt.any_down);
                    fail_total++;
                end else begin
                    want = expected_events.pop_front();
                    if (i_evt.key_event !== want.key_event)
                        flag_field("key_event", int'(want.key_event),
                                   int'(i_evt.key_event));
                    if (i_evt.event_key !== want.event_key)
                        flag_field("event_key", int'(want.event_key),
                                   int'(i_evt.event_key));
                    if (i_evt.any_down !== want.any_down)
                        flag_field("any_down", int'(want.any_down),
                                   int'(i_evt.any_down));
                end
            end
            o_pending    <= expected_events.size();
            o_fail_count <= fail_total;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives key samples and register writes into the keypad debounce and hold
// block: a short directed run, then press, hold and release sequences with
// random content and noise under several register settings, with random
// gaps on the sample side and random stalls on the event side.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kpd_pkg::*;

    localparam int PHASES      = 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_WAIT    = 18;

    localparam logic [TIME_W-1:0] HOLD_PLAN [PHASES] = '{
        32'd500, 32'd0, 32'hFFFF_FFFF, 32'd37, 32'd1000, 32'd1, 32'h8000_0000
    };
    localparam logic [TALLY_W-1:0] DEBOUNCE_PLAN [PHASES] = '{
        8'd3, 8'd1, 8'd255, 8'd0, 8'd2, 8'd8, 8'd1
    };
    localparam int WORD_PLAN [PHASES] = '{120, 110, 500, 80, 80, 80, 60};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic sink_ready   = 1'b0;
    logic sink_idle_on = 1'b1;
    int   sink_wait    = 0;
    logic src_idle_on  = 1'b1;

    int   cycle_cnt = 0;
    int   sent      = 0;
    int   words_pending;
    int   fail_count;

    logic [TIME_W-1:0]  key_last_now [KEY_SLOTS];
    logic [TIME_W-1:0]  cur_hold;
    logic [TALLY_W-1:0] cur_deb;

    kpd_key_if key_ch ();
    kpd_evt_if evt_ch ();
    kpd_cfg_if cfg_ch ();

    assign evt_ch.ready = sink_ready;

    keypad_key_debounce_hold_fsm dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_ch),
        .o_evt   (evt_ch),
        .i_cfg   (cfg_ch)
    );

    kpd_event_checker checker_0 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (key_ch),
        .i_evt        (evt_ch),
        .i_cfg        (cfg_ch),
        .o_pending    (words_pending),
        .o_fail_count (fail_count)
    );

    always #6ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // event side: stall a drawn number of cycles after each taken word
    always @(posedge i_clk) begin
        int next_wait;
        if (!i_rst_n) begin
            sink_wait  <= 0;
            sink_ready <= 1'b0;
        end else begin
            next_wait = sink_wait;
            if (evt_ch.valid && evt_ch.ready)
                next_wait = sink_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            else if (sink_wait > 0)
                next_wait = sink_wait - 1;
            sink_wait  <= next_wait;
            sink_ready <= (next_wait == 0);
        end
    end

    task automatic send_word(input logic [KEY_IDX_W-1:0] k, input logic down,
                             input logic [TIME_W-1:0] now);
        int gap;
        gap = src_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            key_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        key_ch.valid     <= 1'b1;
        key_ch.key_index <= k;
        key_ch.key_down  <= down;
        key_ch.now_ms    <= now;
        do @(posedge i_clk); while (!key_ch.ready);
        key_last_now[k] = now;
        sent++;
    endtask

    task automatic drain_words();
        key_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [TIME_W-1:0] hold,
                                input logic [TALLY_W-1:0] deb);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= REG_HOLD_TIME;
        cfg_ch.wr_data   <= hold;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.reg_index <= REG_DEBOUNCE;
        cfg_ch.wr_data   <= {{(CFG_DATA_W-TALLY_W){1'b0}}, deb};
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_hold = hold;
        cur_deb  = deb;
    endtask

    // aim near the hold boundary of the key, near its last sample, near half the hold time, or anywhere
    function automatic logic [TIME_W-1:0] pick_time(input logic [KEY_IDX_W-1:0] k);
        case ($urandom_range(0, 3))
            0:       return key_last_now[k] + cur_hold - 1 + $urandom_range(0, 2);
            1:       return key_last_now[k] + $urandom_range(0, 200);
            2:       return $urandom();
            default: return key_last_now[k] + (cur_hold >> 1) + $urandom_range(0, 3);
        endcase
    endfunction

    task automatic sequence_step(input logic [KEY_IDX_W-1:0] k, input logic down);
        if ($urandom_range(0, 5) == 0)
            send_word(KEY_IDX_W'($urandom_range(0, KEY_CNT - 1)),
                      1'($urandom_range(0, 1)), $urandom());
        send_word(k, down, pick_time(k));
    endtask

    task automatic run_sequences(input int budget);
        int                   stop_at;
        int                   need;
        int                   n;
        int                   mode;
        logic [KEY_IDX_W-1:0] k;
        stop_at = sent + budget;
        while (sent < stop_at) begin
            mode         = $urandom_range(0, 3);
            src_idle_on  = mode[0];
            sink_idle_on <= mode[1];
            k    = KEY_IDX_W'($urandom_range(0, KEY_CNT - 1));
            need = (cur_deb == 0) ? 1 : int'(cur_deb);
            // press, bounce now and then, then hold down for a while
            n = need + $urandom_range(0, 6);
            for (int i = 0; i < n && sent < stop_at; i++)
                sequence_step(k, $urandom_range(0, 7) != 0);
            // release, with a trailing open sample to reach idle
            n = need + 1 + $urandom_range(0, 2);
            for (int i = 0; i < n && sent < stop_at; i++)
                sequence_step(k, $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic run_directed();
        send_word(4'd0,  1'b1, 32'd1000);
        send_word(4'd0,  1'b1, 32'd1000);
        send_word(4'd0,  1'b1, 32'd1000);
        send_word(4'd0,  1'b1, 32'd1499);
        send_word(4'd0,  1'b1, 32'd1500);
        send_word(4'd0,  1'b1, 32'd2000);
        send_word(4'd0,  1'b0, 32'd2001);
        send_word(4'd0,  1'b0, 32'd2002);
        send_word(4'd0,  1'b0, 32'd2003);
        send_word(4'd0,  1'b0, 32'd2004);
        send_word(4'd0,  1'b0, 32'd2005);
        send_word(4'd15, 1'b1, 32'd0);
        send_word(4'd15, 1'b0, 32'd1);
        send_word(4'd15, 1'b1, 32'd2);
        send_word(4'd15, 1'b1, 32'hFFFF_FFFF);
        send_word(4'd15, 1'b0, 32'd10);
        send_word(4'd15, 1'b1, 32'd20);
        send_word(4'd15, 1'b0, 32'd30);
        send_word(4'd15, 1'b0, 32'd40);
        send_word(4'd15, 1'b1, 32'd50);
        send_word(4'd15, 1'b0, 32'd60);
        send_word(4'd7,  1'b1, 32'hFFFF_FFFE);
        send_word(4'd7,  1'b1, 32'hFFFF_FFFE);
        send_word(4'd7,  1'b1, 32'hFFFF_FFFE);
        send_word(4'd7,  1'b1, 32'h0000_01F2);
    endtask

    initial begin
        key_ch.valid     = 1'b0;
        key_ch.key_index = '0;
        key_ch.key_down  = 1'b0;
        key_ch.now_ms    = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = REG_HOLD_TIME;
        cfg_ch.wr_data   = '0;
        cur_hold         = HOLD_TIME_RST;
        cur_deb          = DEBOUNCE_RST;
        for (int k = 0; k < KEY_SLOTS; k++)
            key_last_now[k] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain_words();
                write_config(HOLD_PLAN[ph], DEBOUNCE_PLAN[ph]);
            end
            run_sequences(WORD_PLAN[ph]);
        end
        drain_words();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
